// ===== rtl/core/frame_perceived_brightness_top_defines.svh =====
// ============================================================================
// Assertion macros for the frame perceived brightness block
// Shared property wrappers clocked on clk, one of them qualified by rst_n.
// ============================================================================
`ifndef FRAME_PERCEIVED_BRIGHTNESS_TOP_DEFINES_SVH
`define FRAME_PERCEIVED_BRIGHTNESS_TOP_DEFINES_SVH

// Property that is checked only outside of reset.
`define FPB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property that is checked at every clock edge, reset included.
`define FPB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/fpb_pkg.sv =====
// ============================================================================
// Frame perceived brightness package
// Widths, constants, weights, types and state codes shared by the block.
// ============================================================================
package fpb_pkg;

  // Field widths.
  localparam int unsigned COLOR_W  = 8;
  localparam int unsigned STRIDE_W = 5;
  localparam int unsigned PHASE_W  = 4;
  localparam int unsigned CNT_W    = 25;
  localparam int unsigned SUM_W    = 32;
  localparam int unsigned SQ_W     = 2 * COLOR_W;
  localparam int unsigned WGT_W    = 16;
  localparam int unsigned PROD_W   = SQ_W + WGT_W;
  localparam int unsigned ROOT_W   = 16;
  localparam int unsigned DVS_W    = SUM_W + 1;

  // Frame length limit and stride limits.
  localparam logic [CNT_W-1:0]    MAX_PIXELS   = CNT_W'(16777216);
  localparam logic [STRIDE_W-1:0] STRIDE_RESET = STRIDE_W'(4);
  localparam logic [STRIDE_W-1:0] STRIDE_MAX   = STRIDE_W'(16);

  // Configuration register map (word index taken from paddr[2]).
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;
  localparam logic        REG_SAMPLE_STRIDE = 1'b0;

  // Color lanes and their Q0.16 weights (red, green, blue).
  localparam int unsigned LANES = 3;
  localparam logic [WGT_W-1:0] WEIGHT [LANES] = '{16'd15794, 16'd45285, 16'd4456};

  // Iteration counts of the divider and the square root unit.
  localparam int unsigned DIV_STEPS  = COLOR_W;
  localparam int unsigned ROOT_STEPS = ROOT_W / 2;
  localparam int unsigned STEP_W     = $clog2(DIV_STEPS);

  // Frame record queue depth.
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  // One finished frame handed from the front to the back.
  typedef struct packed {
    logic [SUM_W-1:0] red_sum;
    logic [SUM_W-1:0] green_sum;
    logic [SUM_W-1:0] blue_sum;
    logic [CNT_W-1:0] sample_count;
    logic             too_long;
  } frame_rec_t;

  // Queue status seen by both sides.
  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  // Back end sequencer states.
  typedef enum logic [2:0] {
    BK_IDLE,
    BK_DIV,
    BK_SQUARE,
    BK_WEIGHT,
    BK_SUM,
    BK_ROOT,
    BK_DONE
  } back_state_t;

endpackage

// ===== rtl/core/fpb_front.sv =====
// ============================================================================
// Frame perceived brightness front end
// Accepts pixels, picks the sampled ones and accumulates per-frame sums.
// ============================================================================
module fpb_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [fpb_pkg::STRIDE_W-1:0]    sample_stride,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [fpb_pkg::COLOR_W-1:0]     in_pixel_red,
  input  logic [fpb_pkg::COLOR_W-1:0]     in_pixel_green,
  input  logic [fpb_pkg::COLOR_W-1:0]     in_pixel_blue,
  input  logic                            in_last_pixel,
  input  fpb_pkg::queue_status_t          q_status,
  output logic                            push,
  output fpb_pkg::frame_rec_t             push_rec
);
  import fpb_pkg::*;

  logic [PHASE_W-1:0]  phase_r, phase_nxt;
  logic [CNT_W-1:0]    pixel_count_r, pixel_count_nxt;
  logic [CNT_W-1:0]    sample_count_r, sample_count_nxt;
  logic [SUM_W-1:0]    red_sum_r, red_sum_nxt;
  logic [SUM_W-1:0]    green_sum_r, green_sum_nxt;
  logic [SUM_W-1:0]    blue_sum_r, blue_sum_nxt;
  logic [STRIDE_W-1:0] stride_eff;
  logic [STRIDE_W-1:0] phase_inc;
  logic                keep;
  logic                accept;

  // A pixel may always enter unless the queue cannot take a frame record.
  assign in_ready = !q_status.full;
  assign accept   = in_valid && in_ready;

  // Clamp the stride into its legal range.
  always_comb begin
    if (sample_stride == '0) begin
      stride_eff = STRIDE_W'(1);
    end else if (sample_stride > STRIDE_MAX) begin
      stride_eff = STRIDE_MAX;
    end else begin
      stride_eff = sample_stride;
    end
  end

  // Next accumulator state for the current pixel.
  always_comb begin
    phase_nxt        = phase_r;
    pixel_count_nxt  = pixel_count_r;
    sample_count_nxt = sample_count_r;
    red_sum_nxt      = red_sum_r;
    green_sum_nxt    = green_sum_r;
    blue_sum_nxt     = blue_sum_r;
    phase_inc        = {1'b0, phase_r} + STRIDE_W'(1);
    keep             = (phase_r == '0);
    if (pixel_count_r < MAX_PIXELS) begin
      if (keep) begin
        red_sum_nxt      = red_sum_r + SUM_W'(in_pixel_red);
        green_sum_nxt    = green_sum_r + SUM_W'(in_pixel_green);
        blue_sum_nxt     = blue_sum_r + SUM_W'(in_pixel_blue);
        sample_count_nxt = sample_count_r + CNT_W'(1);
      end
      phase_nxt       = (phase_inc >= stride_eff) ? '0 : phase_inc[PHASE_W-1:0];
      pixel_count_nxt = pixel_count_r + CNT_W'(1);
    end else begin
      // Saturate one past the limit, which marks the frame as too long.
      pixel_count_nxt = MAX_PIXELS + CNT_W'(1);
    end
  end

  // Hand the finished frame to the queue on its last pixel.
  assign push                  = accept && in_last_pixel;
  assign push_rec.red_sum      = red_sum_nxt;
  assign push_rec.green_sum    = green_sum_nxt;
  assign push_rec.blue_sum     = blue_sum_nxt;
  assign push_rec.sample_count = sample_count_nxt;
  assign push_rec.too_long     = (pixel_count_nxt > MAX_PIXELS);

  // Accumulator registers, cleared at reset and after each frame.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= '0;
      pixel_count_r  <= '0;
      sample_count_r <= '0;
      red_sum_r      <= '0;
      green_sum_r    <= '0;
      blue_sum_r     <= '0;
    end else if (accept) begin
      if (in_last_pixel) begin
        phase_r        <= '0;
        pixel_count_r  <= '0;
        sample_count_r <= '0;
        red_sum_r      <= '0;
        green_sum_r    <= '0;
        blue_sum_r     <= '0;
      end else begin
        phase_r        <= phase_nxt;
        pixel_count_r  <= pixel_count_nxt;
        sample_count_r <= sample_count_nxt;
        red_sum_r      <= red_sum_nxt;
        green_sum_r    <= green_sum_nxt;
        blue_sum_r     <= blue_sum_nxt;
      end
    end
  end

endmodule

// ===== rtl/core/fpb_queue.sv =====
// ============================================================================
// Frame perceived brightness record queue
// Short FIFO of finished frame records between the front and the back.
// ============================================================================
module fpb_queue (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  fpb_pkg::frame_rec_t    push_rec,
  input  logic                   pop,
  output fpb_pkg::frame_rec_t    pop_rec,
  output fpb_pkg::queue_status_t status
);
  import fpb_pkg::*;

  frame_rec_t        mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QPTR_W:0]   count_r;
  logic              do_push;
  logic              do_pop;

  assign status.full  = (count_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign status.empty = (count_r == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign pop_rec      = mem_r[rd_ptr_r];

  // Record storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_rec;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + (QPTR_W+1)'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - (QPTR_W+1)'(1);
      end
    end
  end

endmodule

// ===== rtl/core/fpb_back.sv =====
// ============================================================================
// Frame perceived brightness back end
// Divides the sums into means, weights their squares, takes the square root
// and holds the result in the output register.
// ============================================================================
module fpb_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  fpb_pkg::frame_rec_t         rec,
  input  fpb_pkg::queue_status_t      q_status,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [fpb_pkg::COLOR_W-1:0] out_brightness,
  output logic [fpb_pkg::COLOR_W-1:0] out_mean_red,
  output logic [fpb_pkg::COLOR_W-1:0] out_mean_green,
  output logic [fpb_pkg::COLOR_W-1:0] out_mean_blue,
  output logic                        out_frame_too_long
);
  import fpb_pkg::*;

  back_state_t       state_r, state_nxt;
  logic [STEP_W-1:0] step_r;
  logic [SUM_W-1:0]  rem_r  [LANES];
  logic [COLOR_W-1:0] q_r   [LANES];
  logic [SQ_W-1:0]   sq_r   [LANES];
  logic [PROD_W-1:0] prod_r [LANES];
  logic [DVS_W-1:0]  dvs_r;
  logic              cnt_zero_r;
  logic              too_long_r;
  logic [ROOT_W-1:0] v_r;
  logic [ROOT_W-1:0] root_r;
  logic [ROOT_W-1:0] bit_r;
  logic [DVS_W-1:0]  diff   [LANES];
  logic [LANES-1:0]  ge;
  logic [ROOT_W:0]   root_trial;
  logic              root_ge;
  logic [PROD_W+1:0] wsum;
  logic              out_free;
  logic              out_load;
  logic              out_valid_r;

  // Trial subtraction of each lane's restoring divider.
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      diff[i] = {1'b0, rem_r[i]} - dvs_r;
      ge[i]   = !diff[i][DVS_W-1];
    end
  end

  // Trial step of the digit-by-digit square root.
  assign root_trial = {1'b0, root_r} + {1'b0, bit_r};
  assign root_ge    = ({1'b0, v_r} >= root_trial);

  // Weighted sum of squares, which always fits in 32 bits.
  assign wsum = (PROD_W+2)'(prod_r[0]) + (PROD_W+2)'(prod_r[1]) + (PROD_W+2)'(prod_r[2]);

  assign out_free = !out_valid_r || out_ready;

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: begin
        if (!q_status.empty) state_nxt = BK_DIV;
      end
      BK_DIV: begin
        if (step_r == STEP_W'(DIV_STEPS - 1)) state_nxt = BK_SQUARE;
      end
      BK_SQUARE: state_nxt = BK_WEIGHT;
      BK_WEIGHT: state_nxt = BK_SUM;
      BK_SUM:    state_nxt = BK_ROOT;
      BK_ROOT: begin
        if (step_r == STEP_W'(ROOT_STEPS - 1)) state_nxt = BK_DONE;
      end
      BK_DONE: begin
        if (out_free) state_nxt = BK_IDLE;
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    pop      = 1'b0;
    out_load = 1'b0;
    unique case (state_r)
      BK_IDLE: pop      = !q_status.empty;
      BK_DONE: out_load = out_free;
      default: begin
        pop      = 1'b0;
        out_load = 1'b0;
      end
    endcase
  end

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Datapath: one step of the current operation per cycle.
  always_ff @(posedge clk) begin
    unique case (state_r)
      BK_IDLE: begin
        if (pop) begin
          rem_r[0]   <= rec.red_sum;
          rem_r[1]   <= rec.green_sum;
          rem_r[2]   <= rec.blue_sum;
          dvs_r      <= DVS_W'(rec.sample_count) << (COLOR_W - 1);
          cnt_zero_r <= (rec.sample_count == '0);
          too_long_r <= rec.too_long;
          step_r     <= '0;
        end
      end
      BK_DIV: begin
        for (int i = 0; i < LANES; i++) begin
          if (ge[i]) begin
            rem_r[i] <= diff[i][SUM_W-1:0];
          end
          q_r[i] <= {q_r[i][COLOR_W-2:0], ge[i]};
        end
        dvs_r  <= dvs_r >> 1;
        step_r <= step_r + STEP_W'(1);
      end
      BK_SQUARE: begin
        for (int i = 0; i < LANES; i++) begin
          sq_r[i] <= SQ_W'(q_r[i]) * SQ_W'(q_r[i]);
        end
      end
      BK_WEIGHT: begin
        for (int i = 0; i < LANES; i++) begin
          prod_r[i] <= PROD_W'(WEIGHT[i]) * PROD_W'(sq_r[i]);
        end
      end
      BK_SUM: begin
        // Drop the Q0.16 fraction and start the root from the top digit.
        v_r    <= wsum[PROD_W-1:WGT_W];
        root_r <= '0;
        bit_r  <= ROOT_W'(1) << (ROOT_W - 2);
        step_r <= '0;
      end
      BK_ROOT: begin
        if (root_ge) begin
          v_r    <= v_r - root_trial[ROOT_W-1:0];
          root_r <= (root_r >> 1) + bit_r;
        end else begin
          root_r <= root_r >> 1;
        end
        bit_r  <= bit_r >> 2;
        step_r <= step_r + STEP_W'(1);
      end
      BK_DONE: begin
        step_r <= '0;
      end
      default: begin
        step_r <= '0;
      end
    endcase
  end

  // Output register; a frame with no samples reports black.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_brightness     <= cnt_zero_r ? '0 : root_r[COLOR_W-1:0];
      out_mean_red       <= cnt_zero_r ? '0 : q_r[0];
      out_mean_green     <= cnt_zero_r ? '0 : q_r[1];
      out_mean_blue      <= cnt_zero_r ? '0 : q_r[2];
      out_frame_too_long <= too_long_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== rtl/core/frame_perceived_brightness_top.sv =====
// ============================================================================
// Frame perceived brightness, top level
// Pixels enter at one per clock while the record queue is not full; each
// frame's last pixel yields one result with the mean color and its
// perceived brightness. The front accumulator takes a pixel every cycle
// unless that queue is full. After the last pixel is accepted, the frame's
// sums go through a two-entry record queue to the back end, which loads the
// record, runs the restoring dividers, one per lane, that form all three
// means at once, forms the squares, the weights and their sum, runs the
// square root, and loads the output register once that register is free.
// Frames shorter than the back end's work on a frame pace the input, since
// the front stalls only while the record queue is full. The sample stride
// lives at byte address 0 of the APB port.
// ============================================================================
module frame_perceived_brightness_top (
  input  logic                            clk,
  input  logic                            rst_n,
  // APB configuration port.
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [fpb_pkg::PADDR_W-1:0]     paddr,
  input  logic [fpb_pkg::PDATA_W-1:0]     pwdata,
  output logic [fpb_pkg::PDATA_W-1:0]     prdata,
  output logic                            pready,
  // Pixel input channel.
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [fpb_pkg::COLOR_W-1:0]     in_pixel_red,
  input  logic [fpb_pkg::COLOR_W-1:0]     in_pixel_green,
  input  logic [fpb_pkg::COLOR_W-1:0]     in_pixel_blue,
  input  logic                            in_last_pixel,
  // Frame result channel.
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [fpb_pkg::COLOR_W-1:0]     out_brightness,
  output logic [fpb_pkg::COLOR_W-1:0]     out_mean_red,
  output logic [fpb_pkg::COLOR_W-1:0]     out_mean_green,
  output logic [fpb_pkg::COLOR_W-1:0]     out_mean_blue,
  output logic                            out_frame_too_long
);
  import fpb_pkg::*;

  logic [STRIDE_W-1:0] sample_stride_r;
  logic                reg_sel;
  logic                push;
  logic                pop;
  frame_rec_t          push_rec;
  frame_rec_t          pop_rec;
  queue_status_t       q_status;

  // Register decode by word index.
  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == REG_SAMPLE_STRIDE);
  assign prdata  = reg_sel ? PDATA_W'(sample_stride_r) : '0;

  // Sample stride register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_stride_r <= STRIDE_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      sample_stride_r <= pwdata[STRIDE_W-1:0];
    end
  end

  fpb_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .sample_stride  (sample_stride_r),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_pixel_red   (in_pixel_red),
    .in_pixel_green (in_pixel_green),
    .in_pixel_blue  (in_pixel_blue),
    .in_last_pixel  (in_last_pixel),
    .q_status       (q_status),
    .push           (push),
    .push_rec       (push_rec)
  );

  fpb_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_rec (push_rec),
    .pop      (pop),
    .pop_rec  (pop_rec),
    .status   (q_status)
  );

  fpb_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .rec                (pop_rec),
    .q_status           (q_status),
    .pop                (pop),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_brightness     (out_brightness),
    .out_mean_red       (out_mean_red),
    .out_mean_green     (out_mean_green),
    .out_mean_blue      (out_mean_blue),
    .out_frame_too_long (out_frame_too_long)
  );

endmodule

// ===== rtl/core/fpb_checker.sv =====
// ============================================================================
// Frame perceived brightness port checker
// Port-level properties of the top level, attached by a bind statement.
// ============================================================================
`include "frame_perceived_brightness_top_defines.svh"

module fpb_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            psel,
  input logic [fpb_pkg::PDATA_W-1:0]     prdata,
  input logic                            pready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [fpb_pkg::COLOR_W-1:0]     out_brightness,
  input logic [fpb_pkg::COLOR_W-1:0]     out_mean_red,
  input logic [fpb_pkg::COLOR_W-1:0]     out_mean_green,
  input logic [fpb_pkg::COLOR_W-1:0]     out_mean_blue,
  input logic                            out_frame_too_long
);
  import fpb_pkg::*;

  // A stalled result transaction keeps its payload.
  property p_out_hold;
    out_valid && !out_ready |=> out_valid && $stable(out_brightness)
      && $stable(out_mean_red) && $stable(out_mean_green)
      && $stable(out_mean_blue) && $stable(out_frame_too_long);
  endproperty

  // The weights sum below one, so brightness never exceeds the largest mean.
  property p_bright_bound;
    out_valid |-> (out_brightness <= out_mean_red) || (out_brightness <= out_mean_green)
      || (out_brightness <= out_mean_blue);
  endproperty

  // Only the stride bits of the register read back.
  property p_read_width;
    psel && pready |-> prdata[PDATA_W-1:STRIDE_W] == '0;
  endproperty

  `FPB_ASSERT(a_out_hold, p_out_hold, "result changed while stalled")

  // Reset empties the output register.
  `FPB_ASSERT_ALWAYS(a_reset_clears, !rst_n |=> !out_valid, "result valid right after reset")

  `FPB_ASSERT(a_bright_bound, p_bright_bound, "brightness above every mean")

  `FPB_ASSERT(a_read_width, p_read_width, "read data above the stride field")

endmodule

bind frame_perceived_brightness_top fpb_checker u_fpb_checker (.*);
